// ----- sv/sme_pkg.sv -----
// Shared types and constants for the Sellmeier index evaluator.
// No dependencies; imported by every module of the block.
`default_nettype none

package sme_pkg;

  // Result status codes.
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StPole = 2'd1;
  localparam logic [1:0] StNeg  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] RegB1 = 3'd0;
  localparam logic [2:0] RegB2 = 3'd1;
  localparam logic [2:0] RegB3 = 3'd2;
  localparam logic [2:0] RegC1 = 3'd3;
  localparam logic [2:0] RegC2 = 3'd4;
  localparam logic [2:0] RegC3 = 3'd5;

  // Fixed-point constants.
  localparam logic [63:0] OneQ28    = 64'd1 << 28;
  localparam logic [63:0] TermClamp = 64'd1 << 61;

  // Sideband that rides along a divider lane.
  typedef struct packed {
    logic valid;
    logic pole;
    logic neg;
  } div_tag_t;

  // Sideband that rides along the square-root pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       sat;
  } sqrt_tag_t;

endpackage

`default_nettype wire

// ----- sv/sme_divider.sv -----
// Pipelined 64-by-32 restoring divider, one quotient bit per stage.
// Depends on sme_pkg for the sideband struct.
`default_nettype none

module sme_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [63:0]       num_i,
  input  wire logic [31:0]       den_i,
  input  wire sme_pkg::div_tag_t tag_i,
  output logic [63:0]            quo_o,
  output sme_pkg::div_tag_t      tag_o
);
  import sme_pkg::*;

  localparam int Steps = 64;

  logic [31:0] rem_q [Steps+1];
  logic [63:0] nq_q  [Steps+1];
  logic [31:0] den_q [Steps+1];
  div_tag_t    tag_q [Steps+1];

  assign rem_q[0] = '0;
  assign nq_q[0]  = num_i;
  assign den_q[0] = den_i;
  assign tag_q[0] = tag_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;
    logic        take;

    // Shift in the next numerator bit and try to subtract the divisor.
    assign trial = {rem_q[k], nq_q[k][63]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign take  = (trial >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else if (en_i) begin
        tag_q[k+1] <= tag_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? diff[31:0] : trial[31:0];
        nq_q[k+1]  <= {nq_q[k][62:0], take};
        den_q[k+1] <= den_q[k];
      end
    end
  end

  assign quo_o = nq_q[Steps];
  assign tag_o = tag_q[Steps];

endmodule

`default_nettype wire

// ----- sv/sme_sqrt.sv -----
// Pipelined 64-bit integer square root, one root bit per stage.
// Depends on sme_pkg for the sideband struct.
`default_nettype none

module sme_sqrt (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic [63:0]        rad_i,
  input  wire sme_pkg::sqrt_tag_t tag_i,
  output logic [31:0]             root_o,
  output sme_pkg::sqrt_tag_t      tag_o
);
  import sme_pkg::*;

  localparam int Steps = 32;

  logic [33:0] rem_q  [Steps+1];
  logic [31:0] root_q [Steps+1];
  logic [63:0] v_q    [Steps+1];
  sqrt_tag_t   tag_q  [Steps+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign v_q[0]    = rad_i;
  assign tag_q[0]  = tag_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [35:0] cur;
    logic [35:0] trial;
    logic        take;

    // Bring down two radicand bits and test root*4+1 against the remainder.
    assign cur   = {rem_q[k], v_q[k][63:62]};
    assign trial = {2'b00, root_q[k], 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else if (en_i) begin
        tag_q[k+1] <= tag_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? 34'(cur - trial) : cur[33:0];
        root_q[k+1] <= {root_q[k][30:0], take};
        v_q[k+1]    <= {v_q[k][61:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[Steps];
  assign tag_o  = tag_q[Steps];

endmodule

`default_nettype wire

// ----- sv/sellmeier_index_evaluator.sv -----
// Three-term Sellmeier refractive index evaluator, fully pipelined.
// Depends on sme_pkg, sme_divider and sme_sqrt.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------
//   input    | in_valid_i / in_stall_o   | wavelength_um_i
//   output   | out_valid_o / out_stall_i | index_o, status_o
//   config   | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// One request is accepted every cycle while the output is not stalled; each result
// passes four front stages, the 64-stage divider lanes, one summing stage and the
// 32-stage square root.
// Reset clears all valid bits and the coefficient registers to zero.
// A stall on the output freezes the whole pipeline until the result is taken.
`default_nettype none

module sellmeier_index_evaluator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [23:0] wavelength_um_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      index_o,
  output logic [1:0]       status_o
);
  import sme_pkg::*;

  logic        en;
  logic [31:0] b_q [3];
  logic [31:0] c_q [3];

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        b_q[i] <= '0;
        c_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegB1:   b_q[0] <= cfg_data_i;
        RegB2:   b_q[1] <= cfg_data_i;
        RegB3:   b_q[2] <= cfg_data_i;
        RegC1:   c_q[0] <= cfg_data_i;
        RegC2:   c_q[1] <= cfg_data_i;
        RegC3:   c_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is held by the consumer.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Stage A: capture the wavelength.
  logic        a_v_q;
  logic [23:0] a_w_q;
  // Stage B: square it.
  logic        b_v_q;
  logic [47:0] b_sq_q;
  // Stage C: pole test, magnitudes and signs.
  logic        c_v_q;
  logic [31:0] c_x_q;
  logic        c_pole_q;
  logic [31:0] c_bmag_q [3];
  logic [31:0] c_dmag_q [3];
  logic        c_neg_q  [3];
  // Stage D: numerators.
  logic        d_v_q;
  logic        d_pole_q;
  logic [63:0] d_num_q  [3];
  logic [31:0] d_dmag_q [3];
  logic        d_neg_q  [3];

  logic [31:0] x;
  assign x = b_sq_q[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_w_q    <= wavelength_um_i;
      b_sq_q   <= 48'(a_w_q) * 48'(a_w_q);
      c_x_q    <= x;
      c_pole_q <= (x == c_q[0]) || (x == c_q[1]) || (x == c_q[2]);
      for (int i = 0; i < 3; i++) begin
        c_bmag_q[i] <= b_q[i][31] ? 32'(-b_q[i]) : b_q[i];
        c_dmag_q[i] <= (x < c_q[i]) ? (c_q[i] - x) : (x - c_q[i]);
        c_neg_q[i]  <= b_q[i][31] ^ (x < c_q[i]);
      end
      d_pole_q <= c_pole_q;
      for (int i = 0; i < 3; i++) begin
        d_num_q[i]  <= 64'(c_bmag_q[i]) * 64'(c_x_q);
        d_dmag_q[i] <= c_dmag_q[i];
        d_neg_q[i]  <= c_neg_q[i];
      end
    end
  end

  // Three divider lanes; each carries valid and pole, but only the first lane's are used.
  logic [63:0] quo [3];
  div_tag_t    qtag [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    div_tag_t tin;
    assign tin = '{valid: d_v_q, pole: d_pole_q, neg: d_neg_q[i]};
    sme_divider u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .num_i  (d_num_q[i]),
      .den_i  (d_dmag_q[i]),
      .tag_i  (tin),
      .quo_o  (quo[i]),
      .tag_o  (qtag[i])
    );
  end

  // Stage E: clamp, apply sign and sum the radicand.
  logic [63:0] term [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      term[i] = (quo[i] > TermClamp) ? TermClamp : quo[i];
      if (qtag[i].neg) begin
        term[i] = 64'(-term[i]);
      end
    end
  end

  logic        e_v_q;
  logic        e_pole_q;
  logic [63:0] e_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= qtag[0].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_pole_q <= qtag[0].pole;
      e_rad_q  <= OneQ28 + term[0] + term[1] + term[2];
    end
  end

  // Classify the radicand and feed the square root.
  sqrt_tag_t stag_in;
  sqrt_tag_t stag_out;
  logic [63:0] sq_in;
  logic [31:0] root;

  always_comb begin
    stag_in.valid = e_v_q;
    stag_in.sat   = (e_rad_q[63:36] != '0);
    if (e_pole_q) begin
      stag_in.status = StPole;
    end else if (e_rad_q[63]) begin
      stag_in.status = StNeg;
    end else begin
      stag_in.status = StOk;
    end
    sq_in = {e_rad_q[35:0], 28'd0};
  end

  sme_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .rad_i  (sq_in),
    .tag_i  (stag_in),
    .root_o (root),
    .tag_o  (stag_out)
  );

  // Result selection on the final stage.
  assign out_valid_o = stag_out.valid;
  assign status_o    = stag_out.status;
  always_comb begin
    if (stag_out.status != StOk) begin
      index_o = '0;
    end else if (stag_out.sat) begin
      index_o = '1;
    end else begin
      index_o = root;
    end
  end

  // The input is held back only while a finished result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A held result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(index_o) && $stable(status_o)))
    else $error("held result changed");

  // Status code three never leaves the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StOk || status_o == StPole || status_o == StNeg))
    else $error("invalid status code");

endmodule

`default_nettype wire

// ----- tb/sv/sme_result_checker.sv -----
// Result checker for the Sellmeier index evaluator: predicts each index from
// the accepted wavelengths and compares with the results. Depends on sme_pkg.
`default_nettype none

module sme_result_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [23:0] wavelength_um_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [31:0] index_i,
  input  wire logic [1:0]  status_i,
  output int               errors_o,
  output int               pending_o
);
  import sme_pkg::*;

  typedef struct packed {
    logic [31:0] index;
    logic [1:0]  status;
  } index_result_t;

  logic [31:0] coef_b [3];
  logic [31:0] coef_c [3];
  index_result_t expected_indexes[$];

  assign pending_o = expected_indexes.size();

  // One Sellmeier term B*x/(x-C), truncated toward zero and clamped.
  function automatic logic signed [63:0] sellmeier_term(logic [31:0] b, logic [31:0] c,
                                                         logic [31:0] x);
    logic        bneg, dneg;
    logic [63:0] bmag, dmag, q;
    bneg = b[31];
    bmag = bneg ? (64'd1 << 32) - {32'd0, b} : {32'd0, b};
    dneg = x < c;
    dmag = dneg ? {32'd0, c - x} : {32'd0, x - c};
    if (dmag == 0) return 0;
    q = (bmag * {32'd0, x}) / dmag;
    if (q > TermClamp) q = TermClamp;
    return (bneg != dneg) ? -$signed(q) : $signed(q);
  endfunction

  // Bitwise integer square root.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] rem, res, bitv;
    rem = v;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic index_result_t predict_index(logic [23:0] w);
    index_result_t         r;
    logic [47:0]           sq;
    logic [31:0]           x;
    logic signed [63:0]    rad;
    logic [63:0]           root;
    sq = 48'(w) * 48'(w);
    x = sq[47:16];
    r = '0;
    if (x == coef_c[0] || x == coef_c[1] || x == coef_c[2]) begin
      r.status = StPole;
      return r;
    end
    rad = $signed(OneQ28);
    for (int k = 0; k < 3; k++) rad += sellmeier_term(coef_b[k], coef_c[k], x);
    if (rad < 0) begin
      r.status = StNeg;
    end else if (rad >= 64'sd1 <<< 36) begin
      r.index = 32'hFFFF_FFFF;
      r.status = StOk;
    end else begin
      root = int_sqrt(rad << 28);
      r.index = root[31:0];
      r.status = StOk;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  // Track configuration, queue predictions and compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    index_result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        coef_b[k] = 0;
        coef_c[k] = 0;
      end
      expected_indexes.delete();
      errors_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        expected_indexes.push_back(predict_index(wavelength_um_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_indexes.size() == 0) begin
          report_mismatch("unexpected result, index", index_i, 32'd0);
        end else begin
          want = expected_indexes.pop_front();
          if (index_i !== want.index) report_mismatch("index", index_i, want.index);
          if (status_i !== want.status)
            report_mismatch("status", {30'd0, status_i}, {30'd0, want.status});
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegB1: coef_b[0] = cfg_data_i;
          RegB2: coef_b[1] = cfg_data_i;
          RegB3: coef_b[2] = cfg_data_i;
          RegC1: coef_c[0] = cfg_data_i;
          RegC2: coef_c[1] = cfg_data_i;
          RegC3: coef_c[2] = cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench top for the Sellmeier index evaluator: drives wavelengths and
// coefficient phases, gives the verdict. Depends on sme_pkg and sme_result_checker.
`default_nettype none

module testbench;
  import sme_pkg::*;

  localparam int Latency = 101;
  localparam int CycleLimit = 400000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_idx = RegB1;
  logic [31:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [23:0] wavelength = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] index;
  logic [1:0]  status;
  int          errors, pending;
  int          cycles = 0;
  bit          hold_long = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  sellmeier_index_evaluator dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .wavelength_um_i(wavelength), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .index_o(index), .status_o(status)
  );

  sme_result_checker checker_inst (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .wavelength_um_i(wavelength), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .index_i(index), .status_i(status), .errors_o(errors), .pending_o(pending)
  );

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("sellmeier_index_evaluator: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // One register write; the caller drops the write enable after the last one.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  task automatic load_coefs(logic [31:0] b1, b2, b3, c1, c2, c3);
    write_reg(RegB1, b1);
    write_reg(RegB2, b2);
    write_reg(RegB3, b3);
    write_reg(RegC1, c1);
    write_reg(RegC2, c2);
    write_reg(RegC3, c3);
    cfg_we <= 0;
  endtask

  // Offer one wavelength and hold it until accepted.
  task automatic send_wavelength(logic [23:0] w, bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    wavelength <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wavelength whose square truncates exactly onto c: try sqrt of c<<16.
  function automatic logic [23:0] pole_wavelength(logic [31:0] c);
    logic [63:0] t;
    logic [23:0] w;
    t = {32'd0, c} << 16;
    w = 0;
    for (int k = 23; k >= 0; k--)
      if ((({40'd0, w} | (64'd1 << k)) * ({40'd0, w} | (64'd1 << k))) <= t) w[k] = 1;
    return w;
  endfunction

  // Random coefficient phase, loosely like real glass or fully random.
  task automatic random_phase(int count);
    logic [31:0] c1, c2, c3;
    logic [23:0] w;
    bit          wild;
    wild = ($urandom_range(0, 2) == 0);
    c1 = wild ? $urandom : $urandom_range(0, 32'h0040_0000);
    c2 = wild ? $urandom : $urandom_range(0, 32'h0100_0000);
    c3 = wild ? $urandom : $urandom_range(0, 32'h8000_0000);
    if (wild)
      load_coefs($urandom, $urandom, $urandom, c1, c2, c3);
    else
      load_coefs($urandom_range(0, 32'h1000_0000), $urandom_range(0, 32'h0800_0000),
                 $urandom_range(0, 32'h4000_0000), c1, c2, c3);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: w = 24'($urandom);
        1: w = pole_wavelength(c1);
        2: w = pole_wavelength(c2);
        default: w = 24'($urandom_range(24'h04_0000, 24'h30_0000));
      endcase
      send_wavelength(w, 0);
    end
    in_valid <= 0;
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset coefficients, extremes of the wavelength, pole at zero.
    send_wavelength(24'h00_0000, 0);
    send_wavelength(24'hFF_FFFF, 0);
    send_wavelength(24'h10_0000, 0);
    in_valid <= 0;
    wait_drained();

    // Glass-like coefficients, pole on each term, huge term and saturation.
    load_coefs(32'h1032_0000, 32'h0060_0000, 32'h0FFF_0000,
               32'h0001_8000, 32'h0005_0000, 32'h6000_0000);
    send_wavelength(24'h08_0000, 0);
    send_wavelength(pole_wavelength(32'h0001_8000), 0);
    send_wavelength(pole_wavelength(32'h0005_0000), 0);
    send_wavelength(pole_wavelength(32'h6000_0000), 0);
    send_wavelength(24'h00_4000, 0);
    send_wavelength(24'h00_6300, 0);
    in_valid <= 0;
    wait_drained();

    // Extreme coefficients: negative radicand, clamping and saturation.
    load_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000);
    send_wavelength(24'hFF_FFFF, 0);
    send_wavelength(24'h00_0100, 0);
    send_wavelength(24'h00_0101, 0);
    send_wavelength(24'h10_0000, 0);
    in_valid <= 0;
    wait_drained();

    // Zero radicand: B1 = -1 with C1 = 0 cancels the constant one.
    load_coefs(32'hF000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_wavelength(24'h12_3456, 0);
    send_wavelength(24'hFF_FFFF, 0);
    in_valid <= 0;
    wait_drained();

    // Back pressure: long receiver hold-off while the sender keeps offering.
    load_coefs(32'h1032_0000, 32'h0060_0000, 32'h0FFF_0000,
               32'h0001_8000, 32'h0005_0000, 32'h6000_0000);
    hold_long = 1;
    for (int k = 0; k < 150; k++) send_wavelength(24'($urandom), 1);
    in_valid <= 0;
    wait_drained();

    for (int p = 0; p < 6; p++) random_phase(45);

    if (errors == 0) begin
      $display("sellmeier_index_evaluator: match");
    end else begin
      $display("sellmeier_index_evaluator: mismatch");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- sim.f -----
sv/sme_pkg.sv
sv/sme_divider.sv
sv/sme_sqrt.sv
sv/sellmeier_index_evaluator.sv
tb/sv/sme_result_checker.sv
tb/sv/testbench.sv
